/* hdl/lqs_pkg.sv */
// shared types and constants for the linear queue with sort
package lqs_pkg;

	localparam int LQS_DEPTH      = 8;
	localparam int LQS_DATA_WIDTH = 32;

	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SORT = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic                enq;        // write word at tail, bump tail
		logic                rd_head;    // read slot at head
		logic                pop;        // remove head entry
		logic                sort_init;  // outer index to head
		logic                rd_i;       // read slot at outer index
		logic                get_i;      // latch outer word, start scan
		logic                rd_j;       // read slot at scan index
		logic                cmp;        // compare scan word with minimum
		logic                wr_i;       // minimum into outer slot
		logic                wr_sel;     // outer word into minimum slot
		logic                out_ld;     // load result register
		logic                out_data;   // result carries read word
		logic [STATUS_W-1:0] out_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic few;       // fewer than two entries
		logic j_last;    // scan index at last occupied slot
		logic i_last;    // outer index at last position to fill
		logic out_free;  // result register free at this edge
	} dp_stat_t;

endpackage

/* hdl/lqs_req_if.sv */
// command channel: valid, ready and one command word
interface lqs_req_if;
	import lqs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

/* hdl/lqs_rsp_if.sv */
// result channel: valid, ready and one result word
interface lqs_rsp_if;
	import lqs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] data;
	logic [COUNT_W-1:0]        count;
	logic                      is_full;
	logic                      is_empty;

	modport source (output valid, output status, output data, output count,
		output is_full, output is_empty, input ready);
	modport sink (input valid, input status, input data, input count,
		input is_full, input is_empty, output ready);
endinterface

/* hdl/lqs_dp.sv */
// queue datapath: entry memory, pointers, sort indices and result register
module lqs_dp #(
	parameter int DEPTH      = lqs_pkg::LQS_DEPTH,
	parameter int DATA_WIDTH = lqs_pkg::LQS_DATA_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lqs_pkg::dp_cmd_t                   ctl,
	output lqs_pkg::dp_stat_t                  stat,
	input  logic signed [lqs_pkg::VALUE_W-1:0] value,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [lqs_pkg::STATUS_W-1:0]       status,
	output logic signed [lqs_pkg::VALUE_W-1:0] data,
	output logic [lqs_pkg::COUNT_W-1:0]        count,
	output logic                               is_full,
	output logic                               is_empty
);
	import lqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int TW = $clog2(DEPTH + 1);

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic signed [DATA_WIDTH-1:0] wr_data;
	logic signed [63:0]           value_ext;

	logic [AW-1:0] head_q;
	logic [TW-1:0] tail_q;
	logic [TW-1:0] head_nx;
	logic [TW-1:0] cnt;

	logic [TW-1:0]                i_q;
	logic [TW-1:0]                j_q;
	logic [AW-1:0]                sel_q;
	logic signed [DATA_WIDTH-1:0] selv_q;
	logic signed [DATA_WIDTH-1:0] iv_q;
	logic [TW:0]                  j_inc;
	logic [TW:0]                  i_inc2;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] data_q;

	assign value_ext = 64'(value);

	always_comb begin
		if (ctl.rd_head) begin
			rd_addr = head_q;
		end else if (ctl.rd_i) begin
			rd_addr = i_q[AW-1:0];
		end else if (ctl.rd_j) begin
			rd_addr = j_q[AW-1:0];
		end else begin
			rd_addr = head_q;
		end
	end

	assign wr_en = ctl.enq | ctl.wr_i | ctl.wr_sel;

	always_comb begin
		if (ctl.enq) begin
			wr_addr = tail_q[AW-1:0];
			wr_data = DATA_WIDTH'(value_ext);
		end else if (ctl.wr_i) begin
			wr_addr = i_q[AW-1:0];
			wr_data = selv_q;
		end else begin
			wr_addr = sel_q;
			wr_data = iv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign head_nx = TW'(head_q) + TW'(1);
	assign cnt     = tail_q - TW'(head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctl.enq) begin
			tail_q <= tail_q + TW'(1);
		end else if (ctl.pop) begin
			if (head_nx >= tail_q) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				head_q <= head_nx[AW-1:0];
			end
		end
	end

	// selection sort indices and running minimum
	always_ff @(posedge clk) begin
		if (ctl.sort_init) begin
			i_q <= TW'(head_q);
		end else if (ctl.wr_sel) begin
			i_q <= i_q + TW'(1);
		end
		if (ctl.get_i) begin
			iv_q   <= rd_q;
			selv_q <= rd_q;
			sel_q  <= i_q[AW-1:0];
			j_q    <= i_q + TW'(1);
		end else if (ctl.cmp) begin
			if (rd_q < selv_q) begin
				selv_q <= rd_q;
				sel_q  <= j_q[AW-1:0];
			end
			j_q <= j_q + TW'(1);
		end
	end

	assign j_inc  = {1'b0, j_q} + (TW + 1)'(1);
	assign i_inc2 = {1'b0, i_q} + (TW + 1)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			status_q <= ctl.out_status;
			data_q   <= ctl.out_data ? VALUE_W'(rd_q) : '0;
		end
	end

	always_comb begin
		stat.full     = (tail_q == TW'(DEPTH));
		stat.empty    = (cnt == '0);
		stat.few      = (cnt < TW'(2));
		stat.j_last   = (j_inc == {1'b0, tail_q});
		stat.i_last   = (i_inc2 >= {1'b0, tail_q});
		stat.out_free = !out_valid_q || out_ready;
	end

	// pointers change only at the edge that loads a result, so the counts
	// shown beside a waiting result stay those after its command
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign count     = COUNT_W'(cnt);
	assign is_full   = stat.full;
	assign is_empty  = stat.empty;

	a_tail_range: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= TW'(DEPTH))
		else $error("tail beyond last slot");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(TW'(head_q) < tail_q) || (head_q == '0 && tail_q == '0))
		else $error("head not below tail");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> stat.out_free)
		else $error("result loaded over a waiting result");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.enq |=> (tail_q == $past(tail_q) + TW'(1)))
		else $error("enqueue did not advance tail");

endmodule

/* hdl/lqs_ctrl.sv */
// queue controller: command decode and selection sort sequencer
module lqs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [lqs_pkg::CMD_W-1:0]     req_cmd,
	output logic                          req_ready,
	input  lqs_pkg::dp_stat_t             stat,
	output lqs_pkg::dp_cmd_t              ctl
);
	import lqs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DQRD = 3'd1;
	localparam logic [2:0] S_RDI  = 3'd2;
	localparam logic [2:0] S_GETI = 3'd3;
	localparam logic [2:0] S_RDJ  = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_WRI  = 3'd6;
	localparam logic [2:0] S_WRS  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       deq_q;
	logic       accept;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_cmd)
						CMD_ENQ: begin
							ctl.out_ld = 1'b1;
							if (stat.full) begin
								ctl.out_status = ST_FULL;
							end else begin
								ctl.enq        = 1'b1;
								ctl.out_status = ST_DONE;
							end
						end
						CMD_DEQ, CMD_PEEK: begin
							if (stat.empty) begin
								ctl.out_ld     = 1'b1;
								ctl.out_status = ST_EMPTY;
							end else begin
								ctl.rd_head = 1'b1;
								state_nx    = S_DQRD;
							end
						end
						CMD_SORT: begin
							if (stat.few) begin
								ctl.out_ld     = 1'b1;
								ctl.out_status = ST_DONE;
							end else begin
								ctl.sort_init = 1'b1;
								state_nx      = S_RDI;
							end
						end
						default: begin
							ctl.out_ld     = 1'b1;
							ctl.out_status = ST_DONE;
						end
					endcase
				end
			end
			S_DQRD: begin
				ctl.out_ld     = 1'b1;
				ctl.out_data   = 1'b1;
				ctl.out_status = ST_DONE;
				ctl.pop        = deq_q;
				state_nx       = S_IDLE;
			end
			S_RDI: begin
				ctl.rd_i = 1'b1;
				state_nx = S_GETI;
			end
			S_GETI: begin
				ctl.get_i = 1'b1;
				state_nx  = S_RDJ;
			end
			S_RDJ: begin
				ctl.rd_j = 1'b1;
				state_nx = S_CMP;
			end
			S_CMP: begin
				ctl.cmp  = 1'b1;
				state_nx = stat.j_last ? S_WRI : S_RDJ;
			end
			S_WRI: begin
				ctl.wr_i = 1'b1;
				state_nx = S_WRS;
			end
			S_WRS: begin
				ctl.wr_sel = 1'b1;
				if (stat.i_last) begin
					ctl.out_ld     = 1'b1;
					ctl.out_status = ST_DONE;
					state_nx       = S_IDLE;
				end else begin
					state_nx = S_RDI;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			deq_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				deq_q <= (req_cmd == CMD_DEQ);
			end
		end
	end

endmodule

/* hdl/linear_queue_with_sort.sv */
// top level of the linear array queue with in-place selection sort
//
// usage
//   req carries one command word: cmd (enqueue, dequeue, peek, sort) and
//   value, the signed word to enqueue. rsp carries one result word per
//   command: status, data, count, is_full and is_empty after the command.
//   the queue is linear: slots freed by dequeue come back only when the
//   queue runs empty and both pointers return to zero.
// sequencing
//   one command at a time. enqueue, and any command answered by a full or
//   empty status, gives its result in the cycle after acceptance. dequeue and
//   peek first read the head through the registered read port of the entry
//   memory, then load the result. sort of n entries (n >= 2) runs: accept,
//   then per position one read, a read and a compare per compared slot and two
//   single-port writes for the swap; zero or one entry is answered directly.
// reset
//   arst_n empties the queue; the entry memory is not cleared.
// back-pressure
//   a result waits in an output register while rsp.ready is low; req.ready
//   stays low until that word is taken or is taken in the same cycle.
module linear_queue_with_sort #(
	parameter int DEPTH      = lqs_pkg::LQS_DEPTH,
	parameter int DATA_WIDTH = lqs_pkg::LQS_DATA_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	lqs_req_if.sink      req,
	lqs_rsp_if.source    rsp
);
	import lqs_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  ctl;
	dp_stat_t stat;

	// state machine: decodes commands and steps the sort
	lqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// entry memory, head/tail pointers, sort registers, result register
	lqs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.value     (req.value),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.status    (rsp.status),
		.data      (rsp.data),
		.count     (rsp.count),
		.is_full   (rsp.is_full),
		.is_empty  (rsp.is_empty)
	);

endmodule

/* tb/tb.sv */
// self-checking testbench for the linear array queue with in-place sort
`timescale 1ns / 100ps

module tb;
	import lqs_pkg::*;

	// one result word as seen on the rsp channel
	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] data;
		logic [COUNT_W-1:0]        count;
		logic                      is_full;
		logic                      is_empty;
	} result_t;

	// queue predictor plus the store of results still owed by the block
	class queue_model;
		result_t                   owed_results[$];
		logic signed [VALUE_W-1:0] slots[LQS_DEPTH];
		int                        head_idx;
		int                        tail_idx;
		int                        used;
		int                        n_cmds;
		int                        n_results;
		int                        n_sorts;
		int                        n_full;
		int                        n_empty;
		int                        n_errors;

		function new();
			head_idx  = 0;
			tail_idx  = 0;
			used      = 0;
			n_cmds    = 0;
			n_results = 0;
			n_sorts   = 0;
			n_full    = 0;
			n_empty   = 0;
			n_errors  = 0;
		endfunction

		// work out the result of one accepted command and queue it up
		function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value);
			result_t                   r;
			int                        last;
			int                        sel;
			logic signed [VALUE_W-1:0] t;
			r.status = ST_DONE;
			r.data   = '0;
			n_cmds++;
			case (cmd)
				CMD_ENQ: begin
					// a linear queue: full once tail hits the end, freed slots or not
					if (tail_idx >= LQS_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						slots[tail_idx] = value;
						tail_idx++;
						used++;
					end
				end
				CMD_DEQ, CMD_PEEK: begin
					if (used == 0 || head_idx >= LQS_DEPTH) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						r.data = slots[head_idx];
						if (cmd == CMD_DEQ) begin
							head_idx++;
							used--;
							// last entry gone: both pointers back to slot zero
							if (head_idx >= tail_idx) begin
								head_idx = 0;
								tail_idx = 0;
								used     = 0;
							end
						end
					end
				end
				default: begin
					// selection sort over the occupied slots, first minimum wins
					n_sorts++;
					last = head_idx + used;
					if (last > LQS_DEPTH)
						last = LQS_DEPTH;
					for (int i = head_idx; i + 1 < last; i++) begin
						sel = i;
						for (int j = i + 1; j < last; j++)
							if (slots[j] < slots[sel])
								sel = j;
						if (sel != i) begin
							t          = slots[i];
							slots[i]   = slots[sel];
							slots[sel] = t;
						end
					end
				end
			endcase
			r.count    = used[COUNT_W-1:0];
			r.is_full  = (tail_idx >= LQS_DEPTH);
			r.is_empty = (used == 0);
			owed_results.push_back(r);
		endfunction

		function void cmp_field(string name, logic [VALUE_W-1:0] e, logic [VALUE_W-1:0] g);
			if (e !== g) begin
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, e, g);
				n_errors++;
			end
		endfunction

		// compare one taken result word with the oldest one owed
		function void check_result(result_t got);
			result_t e;
			n_results++;
			if (owed_results.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, got status %h data %h",
					$time, got.status, got.data);
				n_errors++;
				return;
			end
			e = owed_results.pop_front();
			cmp_field("status", VALUE_W'(e.status), VALUE_W'(got.status));
			cmp_field("data", e.data, got.data);
			cmp_field("count", VALUE_W'(e.count), VALUE_W'(got.count));
			cmp_field("is_full", VALUE_W'(e.is_full), VALUE_W'(got.is_full));
			cmp_field("is_empty", VALUE_W'(e.is_empty), VALUE_W'(got.is_empty));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	lqs_req_if  req_ch ();
	lqs_rsp_if  rsp_ch ();
	queue_model model;

	// percent of cycles the sender sits idle and the receiver holds ready low
	int send_idle_pct = 0;
	int stall_pct     = 0;

	linear_queue_with_sort dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: ready changes on the falling edge only
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	// every command word taken by the block goes to the predictor
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			model.note_command(req_ch.cmd, req_ch.value);
	end

	// every result word taken from the block gets checked
	always @(posedge clk) begin
		result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status   = rsp_ch.status;
			got.data     = rsp_ch.data;
			got.count    = rsp_ch.count;
			got.is_full  = rsp_ch.is_full;
			got.is_empty = rsp_ch.is_empty;
			model.check_result(got);
		end
	end

	// hand one command word to the block, with random idle cycles up front;
	// called and returns at a falling edge
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd   = cmd;
		req_ch.value = value;
		// ready is sampled at the rising edge, before the block updates
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// hold off the sender until every owed result has come back
	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (model.owed_results.size() != 0)
			@(negedge clk);
	endtask

	// mostly full-range words, with a share of extremes and of small values
	// so that sorts see ties and sign changes
	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(7))
			0, 1: pick_word = $signed($urandom_range(8)) - 4;
			2: begin
				case ($urandom_range(3))
					0: pick_word = 32'sh8000_0000;
					1: pick_word = 32'sh7fff_ffff;
					2: pick_word = '0;
					default: pick_word = -1;
				endcase
			end
			default: pick_word = $urandom;
		endcase
	endfunction

	// sort now and then; otherwise enqueue or take from the head by the
	// current fill bias
	function automatic logic [CMD_W-1:0] pick_cmd(int enq_pct);
		int r;
		r = $urandom_range(99);
		if (r < 8)
			pick_cmd = CMD_SORT;
		else if (r < 8 + enq_pct)
			pick_cmd = CMD_ENQ;
		else if ($urandom_range(3) == 0)
			pick_cmd = CMD_PEEK;
		else
			pick_cmd = CMD_DEQ;
	endfunction

	// directed opening: empty answers, one-entry sort, full drop with and
	// without freed slots, sort with extremes and ties, last dequeue
	task automatic run_directed();
		send_word(CMD_PEEK, 32'sh1234_5678);
		send_word(CMD_DEQ, 0);
		send_word(CMD_SORT, 0);
		send_word(CMD_ENQ, 32'sh7fff_ffff);
		send_word(CMD_SORT, 0);
		send_word(CMD_PEEK, 0);
		send_word(CMD_ENQ, 32'sh8000_0000);
		send_word(CMD_ENQ, 0);
		send_word(CMD_ENQ, -1);
		send_word(CMD_ENQ, 32'sh8000_0000);
		send_word(CMD_ENQ, 32'sh5555_5555);
		send_word(CMD_ENQ, 32'shaaaa_aaaa);
		send_word(CMD_ENQ, 1);
		// tail past the last slot: this one is dropped
		send_word(CMD_ENQ, 5);
		send_word(CMD_SORT, 0);
		send_word(CMD_DEQ, 0);
		send_word(CMD_DEQ, 0);
		// head moved on, still full
		send_word(CMD_ENQ, 7);
		send_word(CMD_SORT, 0);
		send_word(CMD_PEEK, 0);
		repeat (6)
			send_word(CMD_DEQ, 0);
		send_word(CMD_DEQ, 0);
		send_word(CMD_ENQ, 3);
		send_word(CMD_DEQ, 0);
	endtask

	// random commands in bursts that lean toward filling, draining or neither
	task automatic run_random(int n_items);
		int enq_pct;
		int burst;
		int left;
		left = n_items;
		while (left > 0) begin
			case ($urandom_range(2))
				0: enq_pct = 70;
				1: enq_pct = 25;
				default: enq_pct = 46;
			endcase
			burst = $urandom_range(40, 8);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_word(pick_cmd(enq_pct), pick_word());
				left--;
			end
		end
	endtask

	// stimulus: reset, directed part, then four idling phases
	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_ENQ;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		arst_n       = 1'b0;
		model        = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		wait_drained();

		// no idling at all
		send_idle_pct = 0;
		stall_pct     = 0;
		run_random(400);
		wait_drained();

		// sender idle most cycles
		send_idle_pct = 65;
		stall_pct     = 0;
		run_random(400);
		wait_drained();

		// receiver stalling most cycles
		send_idle_pct = 0;
		stall_pct     = 65;
		run_random(400);
		wait_drained();

		// light idling on both sides
		send_idle_pct = 7;
		stall_pct     = 7;
		run_random(400);
		wait_drained();

		// wait out the longest sort; catch any stray word
		repeat (100) @(negedge clk);

		$display("ran %0d commands, checked %0d result words", model.n_cmds, model.n_results);
		$display("covered %0d sorts, %0d dropped enqueues, %0d empty answers",
			model.n_sorts, model.n_full, model.n_empty);
		if (model.n_errors == 0 && model.owed_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
